/* rtl/tagged_interval_profiler_unit_assert.svh */
// Assertion macros used by the profiler top level.
`ifndef TAGGED_INTERVAL_PROFILER_UNIT_ASSERT_SVH
`define TAGGED_INTERVAL_PROFILER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the trigger.
`define TIP_ASSERT_SAME(label, clk, rst, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the trigger.
`define TIP_ASSERT_NEXT(label, clk, rst, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tip_pkg.sv */
`default_nettype none
package tip_pkg;
  localparam int SLOT_COUNT = 32;
  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [31:0] WINDOW_RESET = 32'd1000000;

  localparam logic [1:0] CMD_BEGIN = 2'd0;
  localparam logic [1:0] CMD_END   = 2'd1;
  localparam logic [1:0] CMD_OPEN  = 2'd2;
  localparam logic [1:0] CMD_CLOSE = 2'd3;

  typedef struct packed {
    logic find;
    logic open_sess;
    logic alloc_begin;
    logic end_elapsed;
    logic end_write;
    logic flush_start;
    logic scan_next;
    logic div_start;
    logic emit;
    logic flush_finish;
  } tip_cmd_t;

  typedef struct packed {
    logic [1:0] command;
    logic       key_zero;
    logic       sess_open;
    logic       hit;
    logic       free_ok;
    logic       running;
    logic       flush_due;
    logic       qualify;
    logic       rest_none;
    logic       div_done;
    logic       out_free;
  } tip_stat_t;
endpackage
`default_nettype wire

/* rtl/tip_if.sv */
`default_nettype none
interface tip_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] tag_key;
  logic [63:0] timestamp;
  modport source (output valid, command, tag_key, timestamp, input ready);
  modport sink (input valid, command, tag_key, timestamp, output ready);
endinterface

interface tip_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] window_index;
  logic [31:0] row_tag;
  logic [31:0] call_count;
  logic [63:0] total_time;
  logic [63:0] average_time;
  logic        last_row;
  modport source (output valid, window_index, row_tag, call_count, total_time,
                  average_time, last_row, input ready);
  modport sink (input valid, window_index, row_tag, call_count, total_time,
                average_time, last_row, output ready);
endinterface
`default_nettype wire

/* rtl/tip_ctrl.sv */
`default_nettype none
module tip_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_fire,
  input  wire tip_pkg::tip_stat_t stat,
  output tip_pkg::tip_cmd_t      cmd,
  output logic                   idle
);
  import tip_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_FIND   = 4'd1;
  localparam logic [3:0] S_DECIDE = 4'd2;
  localparam logic [3:0] S_ELAP   = 4'd3;
  localparam logic [3:0] S_ACC    = 4'd4;
  localparam logic [3:0] S_SCAN   = 4'd5;
  localparam logic [3:0] S_LOAD   = 4'd6;
  localparam logic [3:0] S_DIV    = 4'd7;
  localparam logic [3:0] S_EMIT   = 4'd8;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign idle = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire) state_next = S_FIND;
      end
      S_FIND: begin
        cmd.find = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        state_next = S_IDLE;
        if (stat.command == CMD_OPEN) begin
          cmd.open_sess = !stat.sess_open;
        end else if (!stat.sess_open) begin
          state_next = S_IDLE;
        end else if (stat.command == CMD_CLOSE) begin
          cmd.flush_start = 1'b1;
          state_next = S_SCAN;
        end else if (stat.key_zero) begin
          state_next = S_IDLE;
        end else if (stat.command == CMD_BEGIN) begin
          cmd.alloc_begin = stat.hit || stat.free_ok;
        end else if (stat.hit && stat.running) begin
          state_next = S_ELAP;
        end
      end
      S_ELAP: begin
        cmd.end_elapsed = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.end_write = 1'b1;
        if (stat.flush_due) begin
          cmd.flush_start = 1'b1;
          state_next = S_SCAN;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if (stat.qualify) begin
          state_next = S_LOAD;
        end else if (stat.rest_none) begin
          cmd.flush_finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      S_LOAD: begin
        cmd.div_start = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.rest_none) begin
            cmd.flush_finish = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.scan_next = 1'b1;
            state_next = S_SCAN;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire

/* rtl/tip_datapath.sv */
`default_nettype none
module tip_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [31:0]       cfg_wdata,
  input  wire logic              in_fire,
  input  wire logic [1:0]        in_command,
  input  wire logic [31:0]       in_tag_key,
  input  wire logic [63:0]       in_timestamp,
  input  wire tip_pkg::tip_cmd_t cmd,
  output tip_pkg::tip_stat_t     stat,
  tip_out_if.source              out_ch
);
  import tip_pkg::*;

  logic [31:0] window_length;
  logic [1:0]  cmd_r;
  logic [31:0] key_r;
  logic [63:0] ts_r;
  logic        sess_open;
  logic [63:0] last_flush;
  logic [31:0] win;

  logic [31:0] slot_key [SLOT_COUNT];
  logic [63:0] mem_start [SLOT_COUNT];
  logic [63:0] mem_total [SLOT_COUNT];
  logic [31:0] mem_calls [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] used, running, nz;

  logic [SLOT_W-1:0] idx;
  logic              hit_r, free_r;
  logic [63:0]       rd_start, rd_total;
  logic [31:0]       rd_calls;
  logic [63:0]       elapsed;
  logic              due;

  logic              hit_c, free_c;
  logic [SLOT_W-1:0] hit_idx, free_idx;
  logic [SLOT_COUNT-1:0] qual, above;

  logic        div_busy;
  logic [5:0]  div_cnt;
  logic [63:0] quo;
  logic [31:0] rem, dvs;
  logic [32:0] shifted;

  logic        out_valid;
  logic [31:0] o_win, o_tag, o_calls;
  logic [63:0] o_total, o_avg;
  logic        o_last;

  // Parallel tag match and first free slot; the lowest index wins both.
  always_comb begin
    hit_c = 1'b0;
    free_c = 1'b0;
    hit_idx = '0;
    free_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (used[i] && slot_key[i] == key_r) begin
        hit_c = 1'b1;
        hit_idx = SLOT_W'(i);
      end
      if (!used[i]) begin
        free_c = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  assign qual = used & nz;
  assign above = ({SLOT_COUNT{1'b1}} << idx) << 1;
  assign shifted = {rem, quo[63]};

  assign stat.command   = cmd_r;
  assign stat.key_zero  = (key_r == '0);
  assign stat.sess_open = sess_open;
  assign stat.hit       = hit_r;
  assign stat.free_ok   = free_r;
  assign stat.running   = running[idx];
  assign stat.flush_due = due;
  assign stat.qualify   = qual[idx];
  assign stat.rest_none = ((qual & above) == '0);
  assign stat.div_done  = !div_busy;
  assign stat.out_free  = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= in_command;
      key_r <= in_tag_key;
      ts_r  <= in_timestamp;
    end
    if (cmd.find) begin
      hit_r <= hit_c;
      free_r <= free_c;
      idx <= hit_c ? hit_idx : free_idx;
    end else if (cmd.flush_start) begin
      idx <= '0;
    end else if (cmd.scan_next) begin
      idx <= idx + SLOT_W'(1);
    end
    rd_start <= mem_start[idx];
    rd_total <= mem_total[idx];
    rd_calls <= mem_calls[idx];
    if (cmd.end_elapsed) begin
      elapsed <= ts_r - rd_start;
      due <= (ts_r - last_flush) >= {32'd0, window_length};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc_begin && !hit_r) slot_key[idx] <= key_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc_begin) mem_start[idx] <= ts_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc_begin && !hit_r) begin
      mem_total[idx] <= '0;
    end else if (cmd.end_write) begin
      mem_total[idx] <= rd_total + elapsed;
    end else if (cmd.emit) begin
      mem_total[idx] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc_begin && !hit_r) begin
      mem_calls[idx] <= '0;
    end else if (cmd.end_write) begin
      mem_calls[idx] <= rd_calls + 32'd1;
    end else if (cmd.emit) begin
      mem_calls[idx] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      running <= '0;
      nz <= '0;
      sess_open <= 1'b0;
      last_flush <= '0;
      win <= '0;
      window_length <= WINDOW_RESET;
    end else begin
      if (cfg_we) window_length <= cfg_wdata;
      if (cmd.alloc_begin) begin
        used[idx] <= 1'b1;
        running[idx] <= 1'b1;
        if (!hit_r) nz[idx] <= 1'b0;
      end
      if (cmd.end_write) begin
        running[idx] <= 1'b0;
        // The flag follows the new count, which is zero again when it wraps.
        nz[idx] <= (rd_calls != 32'hFFFF_FFFF);
      end
      if (cmd.emit) nz[idx] <= 1'b0;
      if (cmd.open_sess) begin
        sess_open <= 1'b1;
        last_flush <= ts_r;
        win <= '0;
      end
      if (cmd.flush_start) win <= win + 32'd1;
      if (cmd.flush_finish) begin
        last_flush <= ts_r;
        if (cmd_r == CMD_CLOSE) sess_open <= 1'b0;
      end
    end
  end

  // Restoring divider, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_cnt <= '0;
    end else if (cmd.div_start) begin
      div_busy <= 1'b1;
      div_cnt <= '0;
    end else if (div_busy) begin
      div_cnt <= div_cnt + 6'd1;
      if (div_cnt == 6'd63) div_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo <= rd_total;
      rem <= '0;
      dvs <= rd_calls;
    end else if (div_busy) begin
      if (shifted >= {1'b0, dvs}) begin
        rem <= 32'(shifted - {1'b0, dvs});
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= shifted[31:0];
        quo <= {quo[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      o_win <= win;
      o_tag <= slot_key[idx];
      o_calls <= rd_calls;
      o_total <= rd_total;
      o_avg <= quo;
      o_last <= stat.rest_none;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.window_index = o_win;
  assign out_ch.row_tag      = o_tag;
  assign out_ch.call_count   = o_calls;
  assign out_ch.total_time   = o_total;
  assign out_ch.average_time = o_avg;
  assign out_ch.last_row     = o_last;
endmodule
`default_nettype wire

/* rtl/tagged_interval_profiler_unit.sv */
// Begin, open and ignored transactions go through the find and decide states; a counted
// end also goes through the elapsed and accumulate states. A flush walks the slots and,
// for each reported row, runs the one-bit-per-cycle divider and emits the row; input is
// stalled for the whole flush. No new transaction is taken before the last one is done.
// Reset (rst, synchronous, active high) clears the slot flags, closes the
// session, zeroes the window number and restores window_length to 1000000.
`default_nettype none
module tagged_interval_profiler_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  tip_in_if.sink           in_ch,
  tip_out_if.source        out_ch
);
  import tip_pkg::*;
  `include "tagged_interval_profiler_unit_assert.svh"

  tip_cmd_t  cmd;
  tip_stat_t stat;
  logic      idle;
  logic      in_fire;

  // The block takes a new transaction only when the controller is idle; the
  // output register lets a finished row wait without holding up the next one.
  assign in_ch.ready = idle;
  assign in_fire = in_ch.valid && idle;

  // The controller sequences the match, update and flush steps.
  tip_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_fire (in_fire),
    .stat    (stat),
    .cmd     (cmd),
    .idle    (idle)
  );

  // The datapath holds the slot table, the divider and the output register.
  tip_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_fire      (in_fire),
    .in_command   (in_ch.command),
    .in_tag_key   (in_ch.tag_key),
    .in_timestamp (in_ch.timestamp),
    .cmd          (cmd),
    .stat         (stat),
    .out_ch       (out_ch)
  );

  // A row is loaded only into a free output register.
  `TIP_ASSERT_SAME(a_emit_free, clk, rst, cmd.emit, stat.out_free, "row emitted over a held row")
  // An accepted transaction keeps the block busy in the next cycle.
  `TIP_ASSERT_NEXT(a_busy_after, clk, rst, in_fire, !in_ch.ready, "input taken while busy")
  // The divider is busy right after it is started.
  `TIP_ASSERT_NEXT(a_div_busy, clk, rst, cmd.div_start, !stat.div_done, "divider did not start")
  // An emitted row shows up as a valid transaction.
  `TIP_ASSERT_NEXT(a_emit_valid, clk, rst, cmd.emit, out_ch.valid, "emitted row not valid")
endmodule
`default_nettype wire

/* bench/tb_tagged_interval_profiler_unit.sv */
`default_nettype none
module tb_tagged_interval_profiler_unit;
  import tip_pkg::*;

  localparam int NSLOT = SLOT_COUNT;
  localparam int IDLE_PCT = 34;
  localparam int STALL_LIMIT = 20000;
  // Worst flush is 32 rows, each with a full divide, plus the slot walk.
  localparam int DRAIN_CYCLES = 2500;

  // One reported row as it leaves the block.
  typedef struct packed {
    logic [31:0] window_index;
    logic [31:0] row_tag;
    logic [31:0] call_count;
    logic [63:0] total_time;
    logic [63:0] average_time;
    logic        last_row;
  } row_t;

  // One directed transaction and the number of rows it must produce.
  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] tag_key;
    logic [63:0] timestamp;
    logic [7:0]  rows;
  } step_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  tip_in_if  in_ch ();
  tip_out_if out_ch ();

  tagged_interval_profiler_unit dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source)
  );

  // Shadow copy of the slot table, session and window state.
  logic [31:0] tab_key   [NSLOT];
  logic [63:0] tab_start [NSLOT];
  logic [63:0] tab_total [NSLOT];
  logic [31:0] tab_calls [NSLOT];
  logic        tab_used  [NSLOT];
  logic        tab_run   [NSLOT];
  logic        sess_open;
  logic [63:0] flush_time;
  logic [31:0] window_num;
  logic [31:0] window_len;

  row_t        pending_rows[$];
  int          mismatches;
  int          cycle_num;
  int          stall_count;

  // Directed opening: the closed session, open while open, tag zero,
  // unknown and idle ends, restarting a running begin, a flush on an
  // end, two rows in one flush, elapsed time across the 64-bit wrap, close.
  step_t dir_tab [18] = '{
    '{CMD_BEGIN, 32'd5,          64'd0,                   8'd0},
    '{CMD_CLOSE, 32'd0,          64'd0,                   8'd0},
    '{CMD_OPEN,  32'd0,          64'd0,                   8'd0},
    '{CMD_OPEN,  32'd0,          64'd100,                 8'd0},
    '{CMD_BEGIN, 32'd0,          64'd5,                   8'd0},
    '{CMD_END,   32'd0,          64'd6,                   8'd0},
    '{CMD_END,   32'd7,          64'd8,                   8'd0},
    '{CMD_BEGIN, 32'hFFFF_FFFF,  64'd10,                  8'd0},
    '{CMD_BEGIN, 32'hFFFF_FFFF,  64'd20,                  8'd0},
    '{CMD_END,   32'hFFFF_FFFF,  64'd1000020,             8'd1},
    '{CMD_END,   32'hFFFF_FFFF,  64'd1000030,             8'd0},
    '{CMD_BEGIN, 32'd1,          64'd2000000,             8'd0},
    '{CMD_BEGIN, 32'd2,          64'd2000000,             8'd0},
    '{CMD_END,   32'd1,          64'd2000005,             8'd0},
    '{CMD_END,   32'd2,          64'hFFFF_FFFF_FFFF_FFFF, 8'd2},
    '{CMD_BEGIN, 32'd3,          64'hFFFF_FFFF_FFFF_FFFF, 8'd0},
    '{CMD_END,   32'd3,          64'd5,                   8'd0},
    '{CMD_CLOSE, 32'd0,          64'd7,                   8'd1}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Emits one row per used slot with a nonzero count, in slot order,
  // and marks the final one.
  function automatic int flush_window_rows(input logic [63:0] now);
    int   n;
    row_t r;
    n = 0;
    window_num = window_num + 32'd1;
    for (int i = 0; i < NSLOT; i++) begin
      if (tab_used[i] && tab_calls[i] != 0) begin
        r.window_index = window_num;
        r.row_tag      = tab_key[i];
        r.call_count   = tab_calls[i];
        r.total_time   = tab_total[i];
        r.average_time = tab_total[i] / {32'd0, tab_calls[i]};
        r.last_row     = 1'b0;
        pending_rows.push_back(r);
        tab_total[i] = '0;
        tab_calls[i] = '0;
        n++;
      end
    end
    if (n > 0) pending_rows[$].last_row = 1'b1;
    flush_time = now;
    return n;
  endfunction

  function automatic int find_tag(input logic [31:0] tag);
    for (int i = 0; i < NSLOT; i++)
      if (tab_used[i] && tab_key[i] == tag) return i;
    return -1;
  endfunction

  // Updates the shadow state for one accepted transaction and queues the
  // rows it causes; returns how many.
  function automatic int profile_event(input logic [1:0] cmd, input logic [31:0] tag,
                                       input logic [63:0] now);
    int s;
    int n;
    n = 0;
    if (cmd == CMD_OPEN) begin
      if (!sess_open) begin
        flush_time = now;
        window_num = '0;
        sess_open  = 1'b1;
      end
      return 0;
    end
    if (!sess_open) return 0;
    if (cmd == CMD_CLOSE) begin
      n = flush_window_rows(now);
      sess_open = 1'b0;
      return n;
    end
    if (tag == 0) return 0;
    s = find_tag(tag);
    if (cmd == CMD_BEGIN) begin
      if (s < 0) begin
        for (int i = 0; i < NSLOT; i++) begin
          if (!tab_used[i]) begin
            s = i;
            break;
          end
        end
        if (s < 0) return 0;  // table full, the begin is dropped
        tab_key[s]   = tag;
        tab_total[s] = '0;
        tab_calls[s] = '0;
        tab_used[s]  = 1'b1;
      end
      tab_start[s] = now;
      tab_run[s]   = 1'b1;
      return 0;
    end
    if (s < 0 || !tab_run[s]) return 0;
    tab_total[s] = tab_total[s] + (now - tab_start[s]);
    tab_calls[s] = tab_calls[s] + 32'd1;
    tab_run[s]   = 1'b0;
    if (now - flush_time >= {32'd0, window_len}) n = flush_window_rows(now);
    return n;
  endfunction

  // The busy stretch of the run has no idling on either side.
  function automatic bit side_idles();
    if (cycle_num >= 3000 && cycle_num < 6000) return 1'b0;
    return $urandom_range(99) < IDLE_PCT;
  endfunction

  // Presents one transaction, holds it until the block takes it, and
  // predicts its rows. Valid is left high so back-to-back transactions
  // need only one assignment per edge.
  task automatic send_event(input logic [1:0] cmd, input logic [31:0] tag,
                            input logic [63:0] now, output int rows);
    while (side_idles()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= cmd;
    in_ch.tag_key   <= tag;
    in_ch.timestamp <= now;
    do @(posedge clk); while (!in_ch.ready);
    rows = profile_event(cmd, tag, now);
  endtask

  // Waits until every predicted row has come out, then lets a pending
  // empty flush or late transaction finish before anything else happens.
  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_window(input logic [31:0] len);
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we    <= 1'b0;
    window_len = len;
  endtask

  // Result side: compare each accepted row with the oldest prediction and
  // pick a fresh random ready for the next edge.
  always @(posedge clk) begin
    row_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_rows.size() == 0) begin
        flag_mismatch("unexpected row tag", {32'd0, out_ch.row_tag}, 64'd0);
      end else begin
        want = pending_rows.pop_front();
        if (out_ch.window_index !== want.window_index)
          flag_mismatch("window_index", out_ch.window_index, want.window_index);
        if (out_ch.row_tag !== want.row_tag)
          flag_mismatch("row_tag", out_ch.row_tag, want.row_tag);
        if (out_ch.call_count !== want.call_count)
          flag_mismatch("call_count", out_ch.call_count, want.call_count);
        if (out_ch.total_time !== want.total_time)
          flag_mismatch("total_time", out_ch.total_time, want.total_time);
        if (out_ch.average_time !== want.average_time)
          flag_mismatch("average_time", out_ch.average_time, want.average_time);
        if (out_ch.last_row !== want.last_row)
          flag_mismatch("last_row", out_ch.last_row, want.last_row);
      end
    end
    out_ch.ready <= !side_idles();
  end

  // Watchdog: any accepted transaction on either side restarts the count.
  always @(posedge clk) begin
    cycle_num <= cycle_num + 1;
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("tb_tagged_interval_profiler_unit NOT OK");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  initial begin
    logic [31:0] tag_pool [40];
    logic [31:0] started[$];
    logic [31:0] phase_len [4];
    logic [63:0] now;
    logic [31:0] tag;
    int          rows;
    int          pick;
    int          roll;
    int          fresh;

    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.command   = CMD_BEGIN;
    in_ch.tag_key   = '0;
    in_ch.timestamp = '0;
    out_ch.ready    = 1'b0;
    mismatches      = 0;
    cycle_num       = 0;
    stall_count     = 0;
    fresh           = 0;
    for (int i = 0; i < NSLOT; i++) begin
      tab_key[i]   = '0;
      tab_start[i] = '0;
      tab_total[i] = '0;
      tab_calls[i] = '0;
      tab_used[i]  = 1'b0;
      tab_run[i]   = 1'b0;
    end
    sess_open  = 1'b0;
    flush_time = '0;
    window_num = '0;
    window_len = WINDOW_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: the row counts in the table are fixed by hand; the
    // row contents are checked against the shadow model.
    foreach (dir_tab[i]) begin
      send_event(dir_tab[i].command, dir_tab[i].tag_key, dir_tab[i].timestamp, rows);
      if (rows != dir_tab[i].rows)
        flag_mismatch("directed row count", rows, dir_tab[i].rows);
    end
    wait_quiet();

    // Pool of tags, more than there are slots. Begins walk the pool in
    // order, so the table fills and later begins for new tags are dropped.
    // Random tags cover every bit.
    for (int i = 0; i < 40; i++)
      tag_pool[i] = (i < 8) ? i + 1 : ($urandom() | 32'd1);
    tag_pool[8] = 32'hFFFF_FFFF;
    tag_pool[9] = 32'h8000_0000;

    phase_len[0] = 32'd1;
    phase_len[1] = 32'd1500;
    phase_len[2] = 32'hFFFF_FFFF;
    phase_len[3] = 32'd40000;

    for (int p = 0; p < 4; p++) begin
      set_window(phase_len[p]);
      now = {$urandom(), $urandom()};
      send_event(CMD_OPEN, 32'd0, now, rows);
      started.delete();
      for (int k = 0; k < 21; k++) begin
        roll = $urandom_range(99);
        if (roll < 3) begin
          now = {$urandom(), $urandom()};  // jump, possibly across the wrap
        end else begin
          now = now + $urandom_range(0, 2000);
        end
        if (roll < 40 || started.size() == 0) begin
          tag = tag_pool[fresh];
          fresh = (fresh + 1) % 40;
          send_event(CMD_BEGIN, tag, now, rows);
          started.push_back(tag);
        end else if (roll < 85) begin
          pick = $urandom_range(started.size() - 1);
          tag = started[pick];
          started.delete(pick);
          send_event(CMD_END, tag, now, rows);
        end else if (roll < 90) begin
          send_event(2'($urandom_range(1)), 32'd0, now, rows);
        end else if (roll < 94) begin
          send_event(CMD_OPEN, $urandom(), now, rows);
        end else begin
          send_event(CMD_END, $urandom(), now, rows);
        end
      end
      send_event(CMD_CLOSE, $urandom(), now + $urandom_range(0, 100), rows);
      // A little traffic on the closed session, which must be ignored.
      send_event(CMD_END, tag_pool[0], now, rows);
      wait_quiet();
    end

    if (mismatches == 0) begin
      $display("tb_tagged_interval_profiler_unit OK");
    end else begin
      $display("tb_tagged_interval_profiler_unit NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire
